/* design/sm83_pkg.sv */
// Shared types and constants for the SM83 instruction subset execute block.
// Holds opcode codes, cycle counts, flag positions and the state, item and result structs.
// No dependencies.
package sm83_pkg;

   // Implemented opcodes
   localparam logic [7:0] OP_NOP       = 8'h00;
   localparam logic [7:0] OP_DEC_C     = 8'h0D;
   localparam logic [7:0] OP_LD_C_N    = 8'h0E;
   localparam logic [7:0] OP_LD_DE_NN  = 8'h11;
   localparam logic [7:0] OP_LD_MDE_A  = 8'h12;
   localparam logic [7:0] OP_INC_D     = 8'h14;
   localparam logic [7:0] OP_INC_E     = 8'h1C;
   localparam logic [7:0] OP_JR_NZ     = 8'h20;
   localparam logic [7:0] OP_LD_HL_NN  = 8'h21;
   localparam logic [7:0] OP_LD_A_HLI  = 8'h2A;
   localparam logic [7:0] OP_LD_SP_NN  = 8'h31;
   localparam logic [7:0] OP_LD_B_A    = 8'h47;
   localparam logic [7:0] OP_LD_A_B    = 8'h78;
   localparam logic [7:0] OP_JP_NN     = 8'hC3;
   localparam logic [7:0] OP_DI        = 8'hF3;

   // Machine clock cycle counts
   localparam logic [4:0] CYC_4  = 5'd4;
   localparam logic [4:0] CYC_8  = 5'd8;
   localparam logic [4:0] CYC_12 = 5'd12;
   localparam logic [4:0] CYC_16 = 5'd16;

   // Flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   typedef struct packed {
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  d;
      logic [7:0]  e;
      logic [15:0] hl;
      logic [15:0] sp;
      logic [15:0] pc;
      logic [3:0]  flags;
      logic        ie;
      logic        ie_pend;
   } cpu_state_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] imm_low;
      logic [7:0] imm_high;
      logic [7:0] read_data;
   } item_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [4:0]  cycle_count;
      logic        write_enable;
      logic        read_enable;
      logic [15:0] mem_address;
      logic [7:0]  write_data;
      logic [7:0]  acc_value;
      logic [3:0]  flag_bits;
      logic        illegal_op;
   } result_type;

endpackage

/* design/sm83_regfile.sv */
// Architectural register file of the SM83 subset: A-E, HL, SP, PC, flags, interrupt bits.
// Depends on sm83_pkg for the state struct.
module sm83_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  sm83_pkg::cpu_state_type state_in,
   output sm83_pkg::cpu_state_type state_out
);
   import sm83_pkg::*;

   cpu_state_type state_ff;

   // Hold unless an instruction retires; clear everything at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

   assign state_out = state_ff;

endmodule

/* design/sm83_exec.sv */
// Combinational execute logic for one SM83 subset instruction.
// Depends on sm83_pkg for opcodes, cycle counts, flag positions and structs.
module sm83_exec (
   input  sm83_pkg::cpu_state_type state_cur,
   input  sm83_pkg::item_type      item,
   output sm83_pkg::cpu_state_type state_next,
   output sm83_pkg::result_type    result
);
   import sm83_pkg::*;

   function automatic logic [3:0] inc_flags(input logic [7:0] v, input logic [3:0] f);
      logic [3:0] r;
      r         = 4'b0000;
      r[FLAG_C] = f[FLAG_C];
      r[FLAG_Z] = (v == 8'hFF);
      r[FLAG_H] = (v[3:0] == 4'hF);
      return r;
   endfunction

   function automatic logic [3:0] dec_flags(input logic [7:0] v, input logic [3:0] f);
      logic [3:0] r;
      r         = 4'b0000;
      r[FLAG_C] = f[FLAG_C];
      r[FLAG_N] = 1'b1;
      r[FLAG_Z] = (v == 8'h01);
      r[FLAG_H] = (v[3:0] == 4'h0);
      return r;
   endfunction

   logic [15:0] pc_fetch;
   logic [15:0] imm16;
   logic [15:0] jr_offset;

   assign pc_fetch  = state_cur.pc + 16'd1;
   assign imm16     = {item.imm_high, item.imm_low};
   assign jr_offset = {{8{item.imm_low[7]}}, item.imm_low};

   always_comb begin
      state_next          = state_cur;
      state_next.pc       = pc_fetch;
      result              = '0;
      result.cycle_count  = CYC_4;
      case (item.opcode)
         OP_NOP: begin
         end
         OP_DEC_C: begin
            state_next.c     = state_cur.c - 8'd1;
            state_next.flags = dec_flags(state_cur.c, state_cur.flags);
         end
         OP_LD_C_N: begin
            state_next.c       = item.imm_low;
            state_next.pc      = pc_fetch + 16'd1;
            result.cycle_count = CYC_8;
         end
         OP_LD_DE_NN: begin
            state_next.d       = item.imm_high;
            state_next.e       = item.imm_low;
            state_next.pc      = pc_fetch + 16'd2;
            result.cycle_count = CYC_12;
         end
         OP_LD_MDE_A: begin
            result.write_enable = 1'b1;
            result.mem_address  = {state_cur.d, state_cur.e};
            result.write_data   = state_cur.a;
            result.cycle_count  = CYC_8;
         end
         OP_INC_D: begin
            state_next.d     = state_cur.d + 8'd1;
            state_next.flags = inc_flags(state_cur.d, state_cur.flags);
         end
         OP_INC_E: begin
            state_next.e     = state_cur.e + 8'd1;
            state_next.flags = inc_flags(state_cur.e, state_cur.flags);
         end
         OP_JR_NZ: begin
            if (!state_cur.flags[FLAG_Z]) begin
               state_next.pc      = pc_fetch + 16'd1 + jr_offset;
               result.cycle_count = CYC_12;
            end else begin
               state_next.pc      = pc_fetch + 16'd1;
               result.cycle_count = CYC_8;
            end
         end
         OP_LD_HL_NN: begin
            state_next.hl      = imm16;
            state_next.pc      = pc_fetch + 16'd2;
            result.cycle_count = CYC_12;
         end
         OP_LD_A_HLI: begin
            result.read_enable = 1'b1;
            result.mem_address = state_cur.hl;
            state_next.a       = item.read_data;
            state_next.hl      = state_cur.hl + 16'd1;
            result.cycle_count = CYC_8;
         end
         OP_LD_SP_NN: begin
            state_next.sp      = imm16;
            state_next.pc      = pc_fetch + 16'd2;
            result.cycle_count = CYC_12;
         end
         OP_LD_B_A: begin
            state_next.b = state_cur.a;
         end
         OP_LD_A_B: begin
            state_next.a = state_cur.b;
         end
         OP_JP_NN: begin
            state_next.pc      = imm16;
            result.cycle_count = CYC_16;
         end
         OP_DI: begin
            state_next.ie      = 1'b0;
            state_next.ie_pend = 1'b0;
         end
         default: begin
            // Unknown opcode: drop all state changes, keep PC on the opcode.
            state_next        = state_cur;
            result.illegal_op = 1'b1;
         end
      endcase
      result.next_pc   = state_next.pc;
      result.acc_value = state_next.a;
      result.flag_bits = state_next.flags;
   end

endmodule

/* design/sm83_instruction_subset_execute.sv */
// Top level of the SM83 instruction subset execute block.
// Depends on sm83_pkg, sm83_regfile and sm83_exec.
//
// Usage:
//   Request channel (req_valid / req_stall): one transfer carries an opcode, the two
//   bytes that follow it and the byte the bus returns at HL. Response channel
//   (rsp_valid / rsp_stall): one transfer per request with the new PC, cycle count,
//   memory request, A, the flags and the illegal-opcode flag.
//   Path: a taken request waits in the request register, executes into the response
//   register, and rsp_valid rises as the response register loads.
//   Throughput: one instruction per clock while rsp_stall is low; the request
//   register and the register file feed short execute logic (a few 8/16-bit adds)
//   that loads the response register in a single pass.
//   Reset (synchronous, active high): clears all CPU registers to zero and empties
//   both the request and response registers.
//   Stall: while rsp_stall holds a full response register, the request register keeps
//   its item and the register file holds; once that is full too, req_stall rises.
//   Instructions retire strictly in request order.
module sm83_instruction_subset_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_imm_low,
   input  logic [7:0]  req_imm_high,
   input  logic [7:0]  req_read_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_next_pc,
   output logic [4:0]  rsp_cycle_count,
   output logic        rsp_write_enable,
   output logic        rsp_read_enable,
   output logic [15:0] rsp_mem_address,
   output logic [7:0]  rsp_write_data,
   output logic [7:0]  rsp_acc_value,
   output logic [3:0]  rsp_flag_bits,
   output logic        rsp_illegal_op
);
   import sm83_pkg::*;

   logic          req_valid_ff, req_valid_in;
   item_type      req_item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_result_ff;

   cpu_state_type state_cur;
   cpu_state_type state_next;
   result_type    exec_result;

   logic          req_take;
   logic          advance;
   logic          rsp_take;

   // Execute the buffered item when the response register is empty or draining.
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   sm83_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .update    (advance),
      .state_in  (state_next),
      .state_out (state_cur)
   );

   sm83_exec u_exec (
      .state_cur  (state_cur),
      .item       (req_item_ff),
      .state_next (state_next),
      .result     (exec_result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= '{opcode:    req_opcode,
                          imm_low:   req_imm_low,
                          imm_high:  req_imm_high,
                          read_data: req_read_data};
      end
      if (advance) begin
         rsp_result_ff <= exec_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_result_ff.next_pc;
   assign rsp_cycle_count  = rsp_result_ff.cycle_count;
   assign rsp_write_enable = rsp_result_ff.write_enable;
   assign rsp_read_enable  = rsp_result_ff.read_enable;
   assign rsp_mem_address  = rsp_result_ff.mem_address;
   assign rsp_write_data   = rsp_result_ff.write_data;
   assign rsp_acc_value    = rsp_result_ff.acc_value;
   assign rsp_flag_bits    = rsp_result_ff.flag_bits;
   assign rsp_illegal_op   = rsp_result_ff.illegal_op;

endmodule
